>>> design/assert_macros.svh
// Assertion macros shared by the checker files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under reset.
`define ASSERT_IMPLY(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication under reset.
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> design/pic8259_pkg.sv
// Package for the 8259-style interrupt controller core.
// Transaction types, field codes and helper functions; no dependencies.
`timescale 1ns / 1ps

package pic8259_pkg;

    localparam int UNITS_DEFAULT = 2;
    localparam int IRQ_LINES     = 8;

    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_IRQ   = 2'd2;

    localparam logic [1:0] ACT_KEEP   = 2'd0;
    localparam logic [1:0] ACT_ASSERT = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    localparam logic PORT_CMD  = 1'b0;
    localparam logic PORT_MASK = 1'b1;

    // OCW2 operation, bits 7..5
    localparam logic [2:0] OCW2_PRIO_CLR = 3'd0;
    localparam logic [2:0] OCW2_EOI      = 3'd1;
    localparam logic [2:0] OCW2_NOP      = 3'd2;
    localparam logic [2:0] OCW2_SEOI     = 3'd3;
    localparam logic [2:0] OCW2_ROT      = 3'd4;
    localparam logic [2:0] OCW2_EOI_ROT  = 3'd5;
    localparam logic [2:0] OCW2_SET_PRIO = 3'd6;
    localparam logic [2:0] OCW2_SEOI_ROT = 3'd7;

    // OCW3 read-register select, bits 1..0
    localparam logic [1:0] OCW3_READ_IRR = 2'b10;
    localparam logic [1:0] OCW3_READ_ISR = 2'b11;

    localparam int         ICW1_BIT   = 4;
    localparam int         OCW3_BIT   = 3;
    localparam logic [7:0] ICW2_MASK  = 8'hf8;

    typedef struct packed {
        logic [1:0] kind;
        logic       unit;
        logic       port;
        logic [7:0] write_data;
        logic [2:0] irq_number;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [1:0] line_action;
        logic [7:0] vector;
        logic [7:0] request_bits;
    } result_t;

    // Index of the lowest set bit; zero when none is set.
    function automatic logic [2:0] lowest_set(input logic [IRQ_LINES-1:0] v);
        logic [2:0] idx;
        idx = '0;
        for (int i = IRQ_LINES - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = 3'(i);
            end
        end
        return idx;
    endfunction

endpackage

>>> design/pic8259_unit.sv
// One controller instance: state registers, command decode and priority scan.
// Depends on pic8259_pkg.
`timescale 1ns / 1ps

module pic8259_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  pic8259_pkg::item_t   item,
    output pic8259_pkg::result_t result
);

    logic [7:0] mask_reg, mask_next;
    logic [7:0] in_service_reg, in_service_next;
    logic [7:0] pending_reg, pending_next;
    logic [2:0] prio_reg, prio_next;
    logic       exp_icw2_reg, exp_icw2_next;
    logic       exp_icw3_reg, exp_icw3_next;
    logic       exp_icw4_reg, exp_icw4_next;
    logic       armed_reg, armed_next;
    logic [7:0] latched_reg, latched_next;
    logic [7:0] vbase_reg, vbase_next;

    logic [7:0]  d;
    logic [7:0]  spec_bit;
    logic [15:0] isr_dbl;
    logic [7:0]  isr_rot;
    logic [2:0]  eoi_level;
    logic [7:0]  eoi_bit;
    logic        eoi_found;

    logic [7:0] cmd_isr, cmd_irr;
    logic [7:0] cand;
    logic [2:0] win;
    logic [7:0] win_bit;
    logic       do_scan;
    logic [7:0] rd_data;

    assign d        = item.write_data;
    assign spec_bit = 8'b1 << d[2:0];
    assign isr_dbl  = {in_service_reg, in_service_reg};
    assign isr_rot  = isr_dbl[7:0] >> prio_reg | isr_dbl[15:8] << (4'd8 - {1'b0, prio_reg});
    assign eoi_found = |in_service_reg;
    assign eoi_level = prio_reg + pic8259_pkg::lowest_set(isr_rot);
    assign eoi_bit   = 8'b1 << eoi_level;

    always_comb
    begin
        mask_next     = mask_reg;
        cmd_isr       = in_service_reg;
        cmd_irr       = pending_reg;
        prio_next     = prio_reg;
        exp_icw2_next = exp_icw2_reg;
        exp_icw3_next = exp_icw3_reg;
        exp_icw4_next = exp_icw4_reg;
        armed_next    = armed_reg;
        latched_next  = latched_reg;
        vbase_next    = vbase_reg;
        do_scan       = 1'b0;
        rd_data       = '0;

        unique case (item.kind)
            pic8259_pkg::KIND_READ:
            begin
                if (item.port == pic8259_pkg::PORT_CMD) begin
                    if (armed_reg) begin
                        armed_next = 1'b0;
                        rd_data    = latched_reg;
                    end
                end else begin
                    rd_data = mask_reg;
                end
            end
            pic8259_pkg::KIND_WRITE:
            begin
                do_scan = 1'b1;
                if (item.port == pic8259_pkg::PORT_CMD) begin
                    if (d[pic8259_pkg::ICW1_BIT]) begin
                        exp_icw2_next = 1'b1;
                        exp_icw3_next = ~d[1];
                        exp_icw4_next = d[0];
                    end else if (d[pic8259_pkg::OCW3_BIT]) begin
                        if (d[1:0] == pic8259_pkg::OCW3_READ_IRR) begin
                            armed_next   = 1'b1;
                            latched_next = pending_reg;
                        end else if (d[1:0] == pic8259_pkg::OCW3_READ_ISR) begin
                            armed_next   = 1'b1;
                            latched_next = in_service_reg & ~mask_reg;
                        end
                    end else begin
                        unique case (d[7:5])
                            pic8259_pkg::OCW2_PRIO_CLR: prio_next = '0;
                            pic8259_pkg::OCW2_EOI:
                            begin
                                if (eoi_found) begin
                                    cmd_isr = in_service_reg & ~eoi_bit;
                                    cmd_irr = pending_reg & ~eoi_bit;
                                end
                            end
                            pic8259_pkg::OCW2_NOP: ;
                            pic8259_pkg::OCW2_SEOI:
                            begin
                                cmd_isr = in_service_reg & ~spec_bit;
                                if (|(in_service_reg & spec_bit)) begin
                                    cmd_irr = pending_reg & ~spec_bit;
                                end
                            end
                            pic8259_pkg::OCW2_ROT: prio_next = prio_reg + 3'd1;
                            pic8259_pkg::OCW2_EOI_ROT:
                            begin
                                if (eoi_found) begin
                                    cmd_isr   = in_service_reg & ~eoi_bit;
                                    cmd_irr   = pending_reg & ~eoi_bit;
                                    prio_next = prio_reg + 3'd1;
                                end
                            end
                            pic8259_pkg::OCW2_SET_PRIO: prio_next = d[2:0];
                            pic8259_pkg::OCW2_SEOI_ROT:
                            begin
                                if (|(in_service_reg & spec_bit)) begin
                                    cmd_isr   = in_service_reg & ~spec_bit;
                                    cmd_irr   = pending_reg & ~spec_bit;
                                    prio_next = prio_reg + 3'd1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end else begin
                    if (exp_icw2_reg) begin
                        vbase_next    = d & pic8259_pkg::ICW2_MASK;
                        exp_icw2_next = 1'b0;
                    end else if (exp_icw3_reg) begin
                        exp_icw3_next = 1'b0;
                    end else if (exp_icw4_reg) begin
                        exp_icw4_next = 1'b0;
                    end else begin
                        mask_next = d;
                        cmd_isr   = in_service_reg & d;
                        cmd_irr   = pending_reg & d;
                    end
                end
            end
            pic8259_pkg::KIND_IRQ:
            begin
                do_scan = 1'b1;
                cmd_irr = pending_reg | (8'b1 << item.irq_number);
            end
            default: ;
        endcase
    end

    // Fixed-order scan on the post-command state
    assign cand    = cmd_isr | (cmd_irr & ~mask_next);
    assign win     = pic8259_pkg::lowest_set(cand);
    assign win_bit = 8'b1 << win;

    always_comb
    begin
        in_service_next     = cmd_isr;
        pending_next        = cmd_irr;
        result.read_data    = rd_data;
        result.line_action  = pic8259_pkg::ACT_KEEP;
        result.vector       = '0;
        if (do_scan) begin
            if (cand == '0) begin
                result.line_action = pic8259_pkg::ACT_CLEAR;
            end else if (!cmd_isr[win]) begin
                in_service_next    = cmd_isr | win_bit;
                pending_next       = cmd_irr & ~win_bit;
                result.line_action = pic8259_pkg::ACT_ASSERT;
                result.vector      = vbase_next + {5'b0, win};
            end
        end
        result.request_bits = pending_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mask_reg       <= '0;
            in_service_reg <= '0;
            pending_reg    <= '0;
            prio_reg       <= '0;
            exp_icw2_reg   <= 1'b0;
            exp_icw3_reg   <= 1'b0;
            exp_icw4_reg   <= 1'b0;
            armed_reg      <= 1'b0;
            latched_reg    <= '0;
            vbase_reg      <= '0;
        end else if (en) begin
            mask_reg       <= mask_next;
            in_service_reg <= in_service_next;
            pending_reg    <= pending_next;
            prio_reg       <= prio_next;
            exp_icw2_reg   <= exp_icw2_next;
            exp_icw3_reg   <= exp_icw3_next;
            exp_icw4_reg   <= exp_icw4_next;
            armed_reg      <= armed_next;
            latched_reg    <= latched_next;
            vbase_reg      <= vbase_next;
        end
    end

endmodule

>>> design/interrupt_controller_8259_core.sv
// Top level of the 8259-style interrupt controller core.
// Depends on pic8259_pkg and pic8259_unit.
//
// Usage:
//   item channel (item_valid/item_ready/item) carries bus reads, bus writes
//   and interrupt requests, each addressed to one unit. result channel
//   (result_valid/result_ready/result) returns one transaction per item, in
//   order: read data, line action, vector and the unit's pending bits.
//   An accepted item is held in the input register, where its unit's state
//   update and result are computed; both are written when the item advances
//   into the result register, which it does once that register is empty or
//   result_ready is high, and result_valid then rises. Throughput is one item
//   per cycle while result_ready stays high. When result_ready is low the
//   result register holds; the input register still takes one more item,
//   and item_ready then drops until the result is taken. Reset clears all
//   unit state and both pipeline valid flags.
//   Items addressed to a unit beyond UNITS change nothing and return zeros.
`timescale 1ns / 1ps

module interrupt_controller_8259_core #(
    parameter int UNITS = pic8259_pkg::UNITS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  pic8259_pkg::item_t   item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output pic8259_pkg::result_t result
);

    localparam int UW = (UNITS > 1) ? $clog2(UNITS) : 1;

    pic8259_pkg::item_t   item_reg;
    logic                 item_v_reg;
    pic8259_pkg::result_t result_reg, result_next;
    logic                 result_v_reg;

    logic                 adv;
    logic                 in_range;
    logic [UW-1:0]        idx;
    pic8259_pkg::result_t unit_res [UNITS];

    assign adv        = item_v_reg && (!result_v_reg || result_ready);
    assign item_ready = !item_v_reg || adv;
    assign in_range   = (UNITS > 1) || (item_reg.unit == 1'b0);
    assign idx        = UW'(item_reg.unit);

    for (genvar g = 0; g < UNITS; g++) begin : g_unit
        pic8259_unit u_unit (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (adv && in_range && (idx == UW'(g))),
            .item   (item_reg),
            .result (unit_res[g])
        );
    end

    assign result_next = in_range ? unit_res[idx] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            item_v_reg   <= 1'b0;
            result_v_reg <= 1'b0;
        end else begin
            if (item_ready) begin
                item_v_reg <= item_valid;
            end
            if (adv) begin
                result_v_reg <= 1'b1;
            end else if (result_ready) begin
                result_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid) begin
            item_reg <= item;
        end
        if (adv) begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_v_reg;
    assign result       = result_reg;

endmodule

>>> design/pic8259_checker.sv
// Port-level checker for interrupt_controller_8259_core, bound to the top.
// Depends on pic8259_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pic8259_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 item_valid,
    input logic                 item_ready,
    input pic8259_pkg::item_t   item,
    input logic                 result_valid,
    input logic                 result_ready,
    input pic8259_pkg::result_t result
);

    logic in_stalled;
    logic out_stalled;
    logic no_assert;
    logic scanned;

    assign in_stalled  = item_valid && !item_ready;
    assign out_stalled = result_valid && !result_ready;
    assign no_assert   = result_valid && (result.line_action != pic8259_pkg::ACT_ASSERT);
    assign scanned     = result_valid && (result.line_action != pic8259_pkg::ACT_KEEP);

    `ASSERT_NEXT(a_item_hold, clk, rst_n, in_stalled, item_valid && $stable(item))
    `ASSERT_NEXT(a_result_hold, clk, rst_n, out_stalled, result_valid && $stable(result))
    `ASSERT_IMPLY(a_vector_only_on_assert, clk, rst_n, no_assert, result.vector == 8'd0)
    `ASSERT_IMPLY(a_no_read_on_scan, clk, rst_n, scanned, result.read_data == 8'd0)

endmodule

bind interrupt_controller_8259_core pic8259_checker u_pic8259_checker (.*);

>>> sim/tb.sv
// Self-checking testbench for interrupt_controller_8259_core.
// Depends on pic8259_pkg and the core RTL; a queue-fed driver, a clocked monitor
// and an in-file predictor of both controller units check every result transaction.
`timescale 1ns / 1ps

module tb;

    localparam int          NUM_UNITS     = pic8259_pkg::UNITS_DEFAULT;
    localparam logic [1:0]  KIND_RESERVED = 2'd3;
    localparam int          PHASE_ITEMS   = 240;
    localparam int          HOLD_CYCLES   = 80;
    localparam int          HOLD_AFTER    = 120;
    localparam int          SETTLE_CYCLES = 10;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 item_valid = 1'b0;
    logic                 item_ready;
    pic8259_pkg::item_t   item = '0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    pic8259_pkg::result_t result;

    pic8259_pkg::item_t   pending_items[$];
    pic8259_pkg::result_t expected_results[$];

    int      send_idle_pct = 35;
    int      recv_idle_pct = 82;
    logic    recv_hold = 1'b0;
    int      accepted_count = 0;
    int      error_count = 0;

    // predicted controller state, per unit
    logic [7:0] unit_mask[NUM_UNITS];
    logic [7:0] unit_isr[NUM_UNITS];
    logic [7:0] unit_irr[NUM_UNITS];
    logic [2:0] unit_prio[NUM_UNITS];
    logic       want_icw2[NUM_UNITS];
    logic       want_icw3[NUM_UNITS];
    logic       want_icw4[NUM_UNITS];
    logic       status_armed[NUM_UNITS];
    logic [7:0] status_latch[NUM_UNITS];
    logic [7:0] unit_base[NUM_UNITS];

    interrupt_controller_8259_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        for (int u = 0; u < NUM_UNITS; u++)
        begin
            unit_mask[u]    = '0;
            unit_isr[u]     = '0;
            unit_irr[u]     = '0;
            unit_prio[u]    = '0;
            want_icw2[u]    = 1'b0;
            want_icw3[u]    = 1'b0;
            want_icw4[u]    = 1'b0;
            status_armed[u] = 1'b0;
            status_latch[u] = '0;
            unit_base[u]    = '0;
        end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    function automatic void drop_level(input int u, input logic [2:0] lvl);
        unit_isr[u][lvl] = 1'b0;
        unit_irr[u][lvl] = 1'b0;
    endfunction

    // nonspecific EOI: first in-service level from the priority level, wrapping
    function automatic logic drop_next_in_service(input int u);
        logic [2:0] lvl;
        logic       found;
        found = 1'b0;
        for (int k = 0; k < pic8259_pkg::IRQ_LINES; k++)
        begin
            lvl = unit_prio[u] + 3'(k);
            if (!found && unit_isr[u][lvl])
            begin
                drop_level(u, lvl);
                found = 1'b1;
            end
        end
        return found;
    endfunction

    function automatic void apply_command(input int u, input logic [7:0] d);
        if (d[pic8259_pkg::ICW1_BIT])
        begin
            want_icw2[u] = 1'b1;
            want_icw3[u] = ~d[1];
            want_icw4[u] = d[0];
        end
        else if (d[pic8259_pkg::OCW3_BIT])
        begin
            if (d[1:0] == pic8259_pkg::OCW3_READ_IRR)
            begin
                status_armed[u] = 1'b1;
                status_latch[u] = unit_irr[u];
            end
            else if (d[1:0] == pic8259_pkg::OCW3_READ_ISR)
            begin
                status_armed[u] = 1'b1;
                status_latch[u] = unit_isr[u] & ~unit_mask[u];
            end
        end
        else
        begin
            case (d[7:5])
                pic8259_pkg::OCW2_PRIO_CLR: unit_prio[u] = '0;
                pic8259_pkg::OCW2_EOI:      void'(drop_next_in_service(u));
                pic8259_pkg::OCW2_NOP:      ;
                pic8259_pkg::OCW2_SEOI:
                    if (unit_isr[u][d[2:0]])
                        drop_level(u, d[2:0]);
                pic8259_pkg::OCW2_ROT:      unit_prio[u] = unit_prio[u] + 3'd1;
                pic8259_pkg::OCW2_EOI_ROT:
                    if (drop_next_in_service(u))
                        unit_prio[u] = unit_prio[u] + 3'd1;
                pic8259_pkg::OCW2_SET_PRIO: unit_prio[u] = d[2:0];
                pic8259_pkg::OCW2_SEOI_ROT:
                    if (unit_isr[u][d[2:0]])
                    begin
                        drop_level(u, d[2:0]);
                        unit_prio[u] = unit_prio[u] + 3'd1;
                    end
                default: ;
            endcase
        end
    endfunction

    function automatic void apply_mask_port(input int u, input logic [7:0] d);
        if (want_icw2[u])
        begin
            unit_base[u] = d & pic8259_pkg::ICW2_MASK;
            want_icw2[u] = 1'b0;
        end
        else if (want_icw3[u])
            want_icw3[u] = 1'b0;
        else if (want_icw4[u])
            want_icw4[u] = 1'b0;
        else
        begin
            unit_mask[u] = d;
            unit_isr[u]  = unit_isr[u] & d;
            unit_irr[u]  = unit_irr[u] & d;
        end
    endfunction

    // fixed-order priority scan; stops at the first in-service level or unmasked request
    function automatic void scan_unit(input int u, inout pic8259_pkg::result_t r);
        logic done;
        done = 1'b0;
        r.line_action = pic8259_pkg::ACT_CLEAR;
        for (int i = 0; i < pic8259_pkg::IRQ_LINES; i++)
        begin
            if (!done && unit_isr[u][i])
            begin
                r.line_action = pic8259_pkg::ACT_KEEP;
                done = 1'b1;
            end
            else if (!done && unit_irr[u][i] && !unit_mask[u][i])
            begin
                unit_irr[u][i] = 1'b0;
                unit_isr[u][i] = 1'b1;
                r.vector       = unit_base[u] + 8'(i);
                r.line_action  = pic8259_pkg::ACT_ASSERT;
                done = 1'b1;
            end
        end
    endfunction

    function automatic pic8259_pkg::result_t predict_pic_result(input pic8259_pkg::item_t it);
        pic8259_pkg::result_t r;
        int                   u;
        r = '0;
        u = int'(it.unit);
        if (u >= NUM_UNITS)
            return r;
        case (it.kind)
            pic8259_pkg::KIND_READ:
                if (it.port == pic8259_pkg::PORT_CMD)
                begin
                    if (status_armed[u])
                    begin
                        status_armed[u] = 1'b0;
                        r.read_data = status_latch[u];
                    end
                end
                else
                    r.read_data = unit_mask[u];
            pic8259_pkg::KIND_WRITE:
            begin
                if (it.port == pic8259_pkg::PORT_CMD)
                    apply_command(u, it.write_data);
                else
                    apply_mask_port(u, it.write_data);
                scan_unit(u, r);
            end
            pic8259_pkg::KIND_IRQ:
            begin
                unit_irr[u][it.irq_number] = 1'b1;
                scan_unit(u, r);
            end
            default: ;
        endcase
        r.request_bits = unit_irr[u];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("MISMATCH %s: got %02h expected %02h at %0t", what, got, want, $time);
        error_count++;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
        end
        else if (!item_valid || item_ready)
        begin
            if (item_valid)
            begin
                expected_results.push_back(predict_pic_result(item));
                accepted_count++;
            end
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                item_valid <= 1'b1;
                item       <= pending_items.pop_front();
            end
            else
                item_valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected transaction", result.request_bits, 8'h00);
                else
                begin
                    pic8259_pkg::result_t want;
                    want = expected_results.pop_front();
                    if (result.read_data !== want.read_data)
                        report_mismatch("read_data", result.read_data, want.read_data);
                    if (result.line_action !== want.line_action)
                        report_mismatch("line_action", 8'(result.line_action),
                                        8'(want.line_action));
                    if (result.vector !== want.vector)
                        report_mismatch("vector", result.vector, want.vector);
                    if (result.request_bits !== want.request_bits)
                        report_mismatch("request_bits", result.request_bits,
                                        want.request_bits);
                end
            end
            result_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // long receiver stall so the core backs up and drops item_ready
    initial
    begin
        while (accepted_count < HOLD_AFTER)
            @(negedge clk);
        recv_hold = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        recv_hold = 1'b0;
    end

    task automatic push_item(input logic [1:0] kind, input logic unit, input logic port,
                             input logic [7:0] data, input logic [2:0] irq);
        pic8259_pkg::item_t it;
        it.kind       = kind;
        it.unit       = unit;
        it.port       = port;
        it.write_data = data;
        it.irq_number = irq;
        pending_items.push_back(it);
    endtask

    task automatic push_write(input logic unit, input logic port, input logic [7:0] data);
        push_item(pic8259_pkg::KIND_WRITE, unit, port, data, 3'($urandom));
    endtask

    task automatic push_read(input logic unit, input logic port);
        push_item(pic8259_pkg::KIND_READ, unit, port, 8'($urandom), 3'($urandom));
    endtask

    task automatic push_ocw2(input logic unit, input logic [2:0] op, input logic [2:0] lvl);
        push_write(unit, pic8259_pkg::PORT_CMD, {op, 2'b00, lvl});
    endtask

    task automatic add_random_sequence();
        logic       unit;
        logic [7:0] d;
        int         pick;
        unit = 1'($urandom);
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            d = (8'($urandom) & 8'hef) | 8'h10;
            push_write(unit, pic8259_pkg::PORT_CMD, d);
            push_write(unit, pic8259_pkg::PORT_MASK, 8'($urandom));
            if (!d[1] && $urandom_range(9) != 0)
                push_write(unit, pic8259_pkg::PORT_MASK, 8'($urandom));
            if (d[0] && $urandom_range(9) != 0)
                push_write(unit, pic8259_pkg::PORT_MASK, 8'($urandom));
        end
        else if (pick < 42)
            push_item(pic8259_pkg::KIND_IRQ, unit, 1'($urandom), 8'($urandom),
                      3'($urandom));
        else if (pick < 62)
        begin
            if ($urandom_range(1) == 0)
                push_ocw2(unit, $urandom_range(1) ? pic8259_pkg::OCW2_EOI
                                                  : pic8259_pkg::OCW2_EOI_ROT,
                          3'($urandom));
            else
                push_ocw2(unit, 3'($urandom), 3'($urandom));
        end
        else if (pick < 72)
        begin
            d = 8'($urandom);
            d[4] = 1'b0;
            d[3] = 1'b1;
            push_write(unit, pic8259_pkg::PORT_CMD, d);
            push_read(unit, pic8259_pkg::PORT_CMD);
        end
        else if (pick < 80)
        begin
            push_write(unit, pic8259_pkg::PORT_MASK,
                       ($urandom_range(2) == 0) ? 8'($urandom) : 8'h00);
            if ($urandom_range(1) == 0)
                push_read(unit, pic8259_pkg::PORT_MASK);
        end
        else if (pick < 88)
            push_read(unit, 1'($urandom));
        else
            push_item(2'($urandom), unit, 1'($urandom), 8'($urandom), 3'($urandom));
    endtask

    task automatic wait_for_drain();
        while (pending_items.size() != 0 || item_valid || expected_results.size() != 0)
            @(negedge clk);
    endtask

    // stimulus
    initial
    begin
        while (!rst_n)
            @(negedge clk);
        @(negedge clk);

        push_read(1'b0, pic8259_pkg::PORT_CMD);
        push_read(1'b1, pic8259_pkg::PORT_MASK);
        push_item(pic8259_pkg::KIND_IRQ, 1'b0, pic8259_pkg::PORT_CMD, 8'h00, 3'd7);
        push_item(pic8259_pkg::KIND_IRQ, 1'b0, pic8259_pkg::PORT_MASK, 8'hff, 3'd0);
        push_ocw2(1'b0, pic8259_pkg::OCW2_EOI, 3'd0);
        push_ocw2(1'b0, pic8259_pkg::OCW2_SEOI, 3'd7);
        push_write(1'b0, pic8259_pkg::PORT_CMD, 8'h11);
        push_write(1'b0, pic8259_pkg::PORT_MASK, 8'hff);
        push_write(1'b0, pic8259_pkg::PORT_MASK, 8'h04);
        push_write(1'b0, pic8259_pkg::PORT_MASK, 8'h01);
        push_write(1'b1, pic8259_pkg::PORT_CMD, 8'h13);
        push_write(1'b1, pic8259_pkg::PORT_MASK, 8'h20);
        push_write(1'b1, pic8259_pkg::PORT_MASK, 8'h00);
        push_item(pic8259_pkg::KIND_IRQ, 1'b1, pic8259_pkg::PORT_CMD, 8'h00, 3'd3);
        push_item(pic8259_pkg::KIND_IRQ, 1'b1, pic8259_pkg::PORT_CMD, 8'h00, 3'd5);
        push_write(1'b1, pic8259_pkg::PORT_CMD, 8'h08 | 8'(pic8259_pkg::OCW3_READ_IRR));
        push_read(1'b1, pic8259_pkg::PORT_CMD);
        push_write(1'b1, pic8259_pkg::PORT_CMD, 8'h08 | 8'(pic8259_pkg::OCW3_READ_ISR));
        push_read(1'b1, pic8259_pkg::PORT_CMD);
        push_read(1'b1, pic8259_pkg::PORT_CMD);
        push_ocw2(1'b1, pic8259_pkg::OCW2_ROT, 3'd0);
        push_ocw2(1'b1, pic8259_pkg::OCW2_SET_PRIO, 3'd7);
        push_ocw2(1'b1, pic8259_pkg::OCW2_SEOI_ROT, 3'd3);
        push_ocw2(1'b1, pic8259_pkg::OCW2_EOI_ROT, 3'd0);
        push_ocw2(1'b1, pic8259_pkg::OCW2_PRIO_CLR, 3'd0);
        push_ocw2(1'b1, pic8259_pkg::OCW2_NOP, 3'd0);
        push_write(1'b0, pic8259_pkg::PORT_MASK, 8'hff);
        push_read(1'b0, pic8259_pkg::PORT_MASK);
        push_write(1'b0, pic8259_pkg::PORT_MASK, 8'h00);
        push_item(KIND_RESERVED, 1'b0, pic8259_pkg::PORT_MASK, 8'h5a, 3'd2);
        wait_for_drain();

        while (pending_items.size() < PHASE_ITEMS)
            add_random_sequence();
        wait_for_drain();

        send_idle_pct = 82;
        recv_idle_pct = 35;
        while (pending_items.size() < PHASE_ITEMS)
            add_random_sequence();
        wait_for_drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (pending_items.size() < PHASE_ITEMS)
            add_random_sequence();
        wait_for_drain();

        repeat (SETTLE_CYCLES) @(negedge clk);
        if (expected_results.size() != 0)
            report_mismatch("missing transactions", 8'(expected_results.size()), 8'h00);
        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> files.f
+incdir+design
design/pic8259_pkg.sv
design/pic8259_unit.sv
design/interrupt_controller_8259_core.sv
design/pic8259_checker.sv
sim/tb.sv
